// ===== hw/rtl/ipv4p_pkg.sv =====
// shared types and constants for the dotted-decimal ipv4 address parser
`default_nettype none

package ipv4p_pkg;

  // character codes
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;

  // length, dot and octet limits
  localparam logic [4:0] MIN_LEN     = 5'd7;
  localparam logic [4:0] MAX_LEN     = 5'd15;
  localparam logic [4:0] COUNT_SAT   = 5'd16;
  localparam logic [2:0] DOTS_NEEDED = 3'd3;
  localparam logic [2:0] DOT_SAT     = 3'd4;
  localparam logic [8:0] OCTET_SAT   = 9'd256;

  // width of the packed result on the master side
  localparam int unsigned OUT_DATA_W = 40;

  // error codes in priority order
  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_LENGTH      = 3'd1,
    ERR_CHARACTER   = 3'd2,
    ERR_DOT_COUNT   = 3'd3,
    ERR_EMPTY_OCTET = 3'd4,
    ERR_BIG_OCTET   = 3'd5
  } err_t;

  // one parsed address
  typedef struct packed {
    err_t        error_code;
    logic [31:0] address;
  } result_t;

endpackage : ipv4p_pkg

`default_nettype wire

// ===== hw/rtl/ipv4p_scan.sv =====
// input register, per-character parse state and result generation
`default_nettype none

module ipv4p_scan (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,   // [7:0] character
  input  wire logic              s_tlast,   // final character of the text
  input  wire logic              out_free,  // result register can load
  output logic                   res_valid,
  output ipv4p_pkg::result_t     res
);

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;
  logic       advance;

  // parse state
  logic [8:0]  octet_value, octet_value_next;
  logic        octet_has_digit, octet_has_digit_next;
  logic [2:0]  dot_count, dot_count_next;
  logic [4:0]  char_count, char_count_next;
  logic [31:0] address_shift, address_shift_next;
  logic        bad_char_seen, bad_char_seen_next;
  logic        empty_octet_seen, empty_octet_seen_next;
  logic        big_octet_seen, big_octet_seen_next;

  // values after this character, before closing the text
  logic [8:0]  oct_a;
  logic        has_a;
  logic [2:0]  dots_a;
  logic [4:0]  cnt_a;
  logic [31:0] shift_a;
  logic        bad_a, empty_a, big_a;
  logic [31:0] shift_f;
  logic        empty_f, big_f;
  logic        is_digit, is_dot;
  logic [3:0]  digit;
  logic [11:0] prod;
  ipv4p_pkg::err_t code;

  // a non-final character produces nothing, so it never waits on the output
  assign advance  = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // character decode and state update
  always_comb begin
    is_digit = (in_char >= ipv4p_pkg::CHAR_ZERO) && (in_char <= ipv4p_pkg::CHAR_NINE);
    is_dot   = (in_char == ipv4p_pkg::CHAR_DOT);
    digit    = 4'(in_char - ipv4p_pkg::CHAR_ZERO);
    prod     = ({3'b000, octet_value} << 3) + ({3'b000, octet_value} << 1)
             + {8'h00, digit};

    cnt_a   = (char_count < ipv4p_pkg::COUNT_SAT) ? char_count + 5'd1 : char_count;
    oct_a   = octet_value;
    has_a   = octet_has_digit;
    dots_a  = dot_count;
    shift_a = address_shift;
    bad_a   = bad_char_seen;
    empty_a = empty_octet_seen;
    big_a   = big_octet_seen;

    if (is_digit) begin
      oct_a = (prod >= 12'(ipv4p_pkg::OCTET_SAT)) ? ipv4p_pkg::OCTET_SAT : prod[8:0];
      has_a = 1'b1;
    end else if (is_dot) begin
      dots_a  = (dot_count < ipv4p_pkg::DOT_SAT) ? dot_count + 3'd1 : dot_count;
      empty_a = empty_octet_seen | !octet_has_digit;
      big_a   = big_octet_seen | octet_value[8];
      shift_a = {address_shift[23:0], octet_value[7:0]};
      oct_a   = 9'd0;
      has_a   = 1'b0;
    end else begin
      bad_a = 1'b1;
    end

    // close the last octet of the text
    empty_f = empty_a | !has_a;
    big_f   = big_a | oct_a[8];
    shift_f = {shift_a[23:0], oct_a[7:0]};

    // error selection, lowest code wins
    if (cnt_a < ipv4p_pkg::MIN_LEN || cnt_a > ipv4p_pkg::MAX_LEN) begin
      code = ipv4p_pkg::ERR_LENGTH;
    end else if (bad_a) begin
      code = ipv4p_pkg::ERR_CHARACTER;
    end else if (dots_a != ipv4p_pkg::DOTS_NEEDED) begin
      code = ipv4p_pkg::ERR_DOT_COUNT;
    end else if (empty_f) begin
      code = ipv4p_pkg::ERR_EMPTY_OCTET;
    end else if (big_f) begin
      code = ipv4p_pkg::ERR_BIG_OCTET;
    end else begin
      code = ipv4p_pkg::ERR_NONE;
    end

    res.error_code = code;
    res.address    = (code == ipv4p_pkg::ERR_NONE) ? shift_f : 32'd0;
    res_valid      = advance && in_last;

    // next state: hold, step, or clear after the final character
    octet_value_next      = octet_value;
    octet_has_digit_next  = octet_has_digit;
    dot_count_next        = dot_count;
    char_count_next       = char_count;
    address_shift_next    = address_shift;
    bad_char_seen_next    = bad_char_seen;
    empty_octet_seen_next = empty_octet_seen;
    big_octet_seen_next   = big_octet_seen;
    if (advance) begin
      if (in_last) begin
        octet_value_next      = 9'd0;
        octet_has_digit_next  = 1'b0;
        dot_count_next        = 3'd0;
        char_count_next       = 5'd0;
        address_shift_next    = 32'd0;
        bad_char_seen_next    = 1'b0;
        empty_octet_seen_next = 1'b0;
        big_octet_seen_next   = 1'b0;
      end else begin
        octet_value_next      = oct_a;
        octet_has_digit_next  = has_a;
        dot_count_next        = dots_a;
        char_count_next       = cnt_a;
        address_shift_next    = shift_a;
        bad_char_seen_next    = bad_a;
        empty_octet_seen_next = empty_a;
        big_octet_seen_next   = big_a;
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      octet_value      <= 9'd0;
      octet_has_digit  <= 1'b0;
      dot_count        <= 3'd0;
      char_count       <= 5'd0;
      address_shift    <= 32'd0;
      bad_char_seen    <= 1'b0;
      empty_octet_seen <= 1'b0;
      big_octet_seen   <= 1'b0;
    end else begin
      octet_value      <= octet_value_next;
      octet_has_digit  <= octet_has_digit_next;
      dot_count        <= dot_count_next;
      char_count       <= char_count_next;
      address_shift    <= address_shift_next;
      bad_char_seen    <= bad_char_seen_next;
      empty_octet_seen <= empty_octet_seen_next;
      big_octet_seen   <= big_octet_seen_next;
    end
  end

endmodule : ipv4p_scan

`default_nettype wire

// ===== hw/rtl/ipv4p_out_reg.sv =====
// result register on the master side
`default_nettype none

module ipv4p_out_reg (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 res_valid,
  input  wire ipv4p_pkg::result_t                   res,
  output logic                                      out_free,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [ipv4p_pkg::OUT_DATA_W-1:0]          m_tdata
);

  ipv4p_pkg::result_t res_q;

  // free when empty or the held transaction leaves this cycle
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res_valid;
    end
    if (out_free && res_valid) begin
      res_q <= res;
    end
  end

  // address in the low bits, error code above, zero fill to whole bytes
  assign m_tdata = {{(ipv4p_pkg::OUT_DATA_W - $bits(ipv4p_pkg::result_t)){1'b0}}, res_q};

endmodule : ipv4p_out_reg

`default_nettype wire

// ===== hw/rtl/ipv4_text_address_parser.sv =====
// Dotted-decimal IPv4 address parser, top level.
// The slave channel carries the address text, one ASCII character per
// transaction in s_tdata[7:0], with s_tlast high on the final character.
// After the final character the master channel gives one transaction:
// m_tdata[31:0] is the address (first octet in bits 31:24, zero on error)
// and m_tdata[34:32] the error code (0 ok, 1 bad length, 2 bad character,
// 3 dot count not three, 4 empty octet, 5 octet over 255); upper bits zero.
// Characters without s_tlast produce no output transaction.
// Throughput is one character per cycle, except that a final character waits
// while the output register is full. A character passes an input register
// and combinational parse logic; the result of a final character is then
// loaded into the output register, which drives m_tvalid.
// Reset (rst, synchronous, active high) clears the parse state and empties
// both registers. When the receiver holds m_tready low the result stays in
// the output register; non-final characters keep flowing, and a final
// character waits in the input register with s_tready low until the
// output register frees.
`default_nettype none

module ipv4_text_address_parser (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [7:0]                           s_tdata,  // [7:0] character
  input  wire logic                                 s_tlast,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // [31:0] address, [34:32] error_code, [39:35] zero
  output logic [ipv4p_pkg::OUT_DATA_W-1:0]          m_tdata
);

  logic               out_free;
  logic               res_valid;
  ipv4p_pkg::result_t res;

  // parse stage
  ipv4p_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register
  ipv4p_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule : ipv4_text_address_parser

`default_nettype wire
